// File: sv/ficonv_pkg.sv
// Package for the integer convolution block: field widths, item codes,
// configuration register indexes and controller states. No dependencies.
package ficonv_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 11;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 41;
  localparam int PLEN_W   = 12;
  localparam int LENREG_W = 10;
  localparam int CFGIDX_W = 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  typedef enum logic [CFGIDX_W-1:0] {
    REG_LENGTH_A = 1'b0,
    REG_LENGTH_B = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2
  } state_t;

endpackage

// File: sv/ficonv_if.sv
// Handshake channels of the convolution block: request words and response words.
// Depends on ficonv_pkg for the field widths.
interface ficonv_req_if;
  logic                             valid;
  logic                             ready;
  logic [ficonv_pkg::FUNC_W-1:0]    func;
  logic [ficonv_pkg::INDEX_W-1:0]   index;
  logic [ficonv_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, func, index, sample, input ready);
  modport sink   (input valid, func, index, sample, output ready);
endinterface

interface ficonv_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ficonv_pkg::COEF_W-1:0]   coefficient;
  logic                            in_range;
  logic [ficonv_pkg::PLEN_W-1:0]   padded_length;

  modport source (output valid, coefficient, in_range, padded_length, input ready);
  modport sink   (input valid, coefficient, in_range, padded_length, output ready);
endinterface

// File: sv/ficonv_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ficonv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/fft_integer_convolution.sv
// Integer convolution block: load, compute and read over a request channel.
// Depends on ficonv_pkg, ficonv_if.sv and ficonv_ram.
//
// Usage: the req channel carries words with func, index and sample. Loads write
// one element of A or B (indexes at or above MAX_LEN are dropped). A compute
// word forms the product of the first length_a elements of A and length_b
// elements of B, padded to N, the least power of two not below 2*max(length_a,
// length_b+1), capped at MAX_N. It is output-stationary: each of the N
// coefficients is summed by one multiplier in the single multiply-accumulate
// loop on the A and B memories.
// A read word returns one response word through the result memory read, then
// the output register; the next word is taken once that response has entered
// the output register. A stalled receiver holds the response; the block keeps
// taking loads and computes meanwhile. Reset sets both lengths to 1 and N to 4;
// memory contents are not cleared. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user writes it only while idle, not enforced.
module fft_integer_convolution #(
  parameter int MAX_LEN     = 512,
  parameter int MAX_N       = 2048,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ficonv_pkg::CFGIDX_W-1:0]  cfg_index,
  input  logic [ficonv_pkg::LENREG_W-1:0]  cfg_data,
  ficonv_req_if.sink                       req,
  ficonv_rsp_if.source                     rsp
);
  import ficonv_pkg::*;

  localparam int LA_AW = $clog2(MAX_LEN);
  localparam int NA_W  = $clog2(MAX_N);
  localparam int CL_W  = $clog2(MAX_LEN + 1);
  localparam int KW    = $clog2(MAX_N) + 1;
  localparam int PW    = 2 * SAMPLE_BITS;

  state_t state, state_next;

  logic [LENREG_W-1:0] length_a, length_b;
  logic [KW-1:0]       cur_len;
  logic [CL_W-1:0]     la_r, lb_r, ilast;
  logic [KW-1:0]       kcnt;
  logic [CL_W-1:0]     icnt;

  logic accept;
  func_t func_in;
  assign accept  = req.valid && req.ready;
  assign func_in = func_t'(req.func);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_a <= LENREG_W'(1);
      length_b <= LENREG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LENGTH_A: length_a <= cfg_data;
        REG_LENGTH_B: length_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped lengths and padded length for the setup cycle.
  logic [CL_W-1:0] la_c, lb_c;
  logic [KW-1:0]   n_c;
  always_comb begin
    logic [31:0] m;
    la_c = (32'(length_a) > MAX_LEN) ? CL_W'(MAX_LEN) : CL_W'(length_a);
    lb_c = (32'(length_b) > MAX_LEN) ? CL_W'(MAX_LEN) : CL_W'(length_b);
    m    = (32'(la_c) > 32'(lb_c) + 32'd1) ? 32'(la_c) : 32'(lb_c) + 32'd1;
    n_c  = KW'(MAX_N);
    for (int p = NA_W - 1; p >= 0; p--) begin
      if ((32'd1 << p) >= 2 * m) begin
        n_c = KW'(32'd1 << p);
      end
    end
  end

  // Issue stage of the multiply-accumulate loop.
  logic [31:0] jd;
  logic        v0, last0, k_end;
  assign jd    = 32'(kcnt) - 32'(icnt);
  assign v0    = (state == ST_RUN) && (32'(kcnt) >= 32'(icnt)) && (jd < 32'(lb_r))
                 && (icnt < la_r);
  assign last0 = (state == ST_RUN) && (icnt == ilast);
  assign k_end = (kcnt == cur_len - KW'(1));

  // Memories.
  logic [SAMPLE_BITS-1:0] a_rdata, b_rdata;
  logic                   a_we, b_we, res_we, res_re;
  logic [COEF_W-1:0]      res_wdata, res_rdata;
  logic [NA_W-1:0]        res_waddr;
  logic                   load_ok;

  assign load_ok = accept && (32'(req.index) < MAX_LEN);
  assign a_we    = load_ok && (func_in == FUNC_LOAD_A);
  assign b_we    = load_ok && (func_in == FUNC_LOAD_B);
  assign res_re  = accept && (func_in == FUNC_READ);

  ficonv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(LA_AW'(req.index)),
    .wdata(SAMPLE_BITS'(req.sample)), .re(state == ST_RUN),
    .raddr(LA_AW'(icnt)), .rdata(a_rdata)
  );

  ficonv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(LA_AW'(req.index)),
    .wdata(SAMPLE_BITS'(req.sample)), .re(state == ST_RUN),
    .raddr(LA_AW'(jd)), .rdata(b_rdata)
  );

  ficonv_ram #(.WIDTH(COEF_W), .DEPTH(MAX_N)) u_ram_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .re(res_re), .raddr(NA_W'(req.index)), .rdata(res_rdata)
  );

  // Pipeline: read data, product, accumulate and write back.
  logic              v1, l1, v2, l2;
  logic [KW-1:0]     k1, k2;
  logic [PW-1:0]     prod;
  logic [COEF_W-1:0] acc, acc_sum;

  assign acc_sum   = acc + (v2 ? COEF_W'(prod) : COEF_W'(0));
  assign res_we    = l2;
  assign res_wdata = acc_sum;
  assign res_waddr = NA_W'(k2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      l1 <= 1'b0;
      v2 <= 1'b0;
      l2 <= 1'b0;
    end else begin
      v1 <= v0;
      l1 <= last0;
      v2 <= v1;
      l2 <= l1;
    end
    k1   <= kcnt;
    k2   <= k1;
    prod <= PW'(a_rdata) * PW'(b_rdata);
    if (state == ST_SETUP || l2) begin
      acc <= '0;
    end else begin
      acc <= acc_sum;
    end
  end

  // Loop counters and compute setup.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len <= KW'(4);
      kcnt    <= '0;
      icnt    <= '0;
    end else if (state == ST_SETUP) begin
      cur_len <= n_c;
      kcnt    <= '0;
      icnt    <= '0;
    end else if (state == ST_RUN) begin
      if (last0) begin
        icnt <= '0;
        kcnt <= kcnt + KW'(1);
      end else begin
        icnt <= icnt + CL_W'(1);
      end
    end
    if (state == ST_SETUP) begin
      la_r  <= la_c;
      lb_r  <= lb_c;
      ilast <= (la_c == '0) ? '0 : la_c - CL_W'(1);
    end
  end

  // Read response path. The padded length is captured with the word, so a
  // compute taken while the word waits does not change it.
  logic              inr_p;
  logic              out_valid, out_inr;
  logic [COEF_W-1:0] out_coef;
  logic [PLEN_W-1:0] out_plen;
  logic              out_load;

  assign out_load = (state == ST_RDWAIT) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (res_re) begin
      inr_p <= (32'(req.index) < 32'(cur_len)) && (32'(req.index) < MAX_N);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_inr  <= inr_p;
      out_coef <= inr_p ? res_rdata : '0;
      out_plen <= PLEN_W'(cur_len);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.coefficient   = out_coef;
  assign rsp.in_range      = out_inr;
  assign rsp.padded_length = out_plen;

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && func_in == FUNC_COMPUTE) begin
          state_next = ST_SETUP;
        end else if (accept && func_in == FUNC_READ) begin
          state_next = ST_RDWAIT;
        end
      end
      ST_RDWAIT: if (!out_valid || rsp.ready) state_next = ST_IDLE;
      ST_SETUP:  state_next = ST_RUN;
      ST_RUN:    if (last0 && k_end) state_next = ST_DRAIN1;
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
  end

`ifndef SYNTHESIS
  a_res_write_in_compute: assert property (@(posedge clk) disable iff (rst)
    res_we |-> (state == ST_RUN || state == ST_DRAIN1 || state == ST_DRAIN2))
    else $error("result memory written outside a compute");

  a_len_pow2: assert property (@(posedge clk) disable iff (rst)
    $onehot(cur_len))
    else $error("padded length is not a power of two");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.in_range) |-> (rsp.coefficient == '0))
    else $error("out-of-range word carries a nonzero coefficient");

  a_read_fetch: assert property (@(posedge clk) disable iff (rst)
    res_re |=> (state == ST_RDWAIT))
    else $error("read word did not start a fetch");
`endif

endmodule
